@@ sv/dro_pkg.sv @@
// Shared constants, types and the quarter-wave sine table for the odometry block.
// The table is built when the design is elaborated; no other package is used.
`default_nettype none

package dro_pkg;

  localparam int unsigned POS_W         = 48;
  localparam int unsigned FRAC_DEFAULT  = 24;
  localparam int unsigned DPP_W         = 24;
  localparam int unsigned PULSE_W       = 10;
  localparam int unsigned HEAD_W        = 10;
  localparam int unsigned DIR_W         = 2;
  localparam int unsigned TRIG_W        = 16;
  localparam int unsigned MAG_W         = 15;
  localparam int unsigned DIST_W        = DPP_W + PULSE_W;
  localparam int unsigned PROD_W        = DIST_W + MAG_W;
  localparam int unsigned TRIG_FRAC     = 39;
  localparam int unsigned ANGLE_W       = 9;
  localparam int unsigned IDX_W         = 7;
  localparam int unsigned ANGLE_STEPS   = 360;
  localparam int unsigned QUARTER       = 90;
  localparam int unsigned HALF          = 180;
  localparam int unsigned THREE_QUARTER = 270;

  localparam logic [DPP_W-1:0] DPP_RESET = 24'd16777;
  localparam logic [DIR_W-1:0] DIR_REVERSE = 2'd0;

  localparam longint unsigned Q30_ONE = 64'd1073741824;
  localparam longint unsigned PI_Q30  = 64'd3373259426;

  typedef logic [MAG_W-1:0] sine_rom_t [0:QUARTER];

  typedef struct packed {
    logic [TRIG_W-1:0] cos_val;
    logic [TRIG_W-1:0] sin_val;
    logic [MAG_W-1:0]  cos_mag;
    logic [MAG_W-1:0]  sin_mag;
    logic              cos_neg;
    logic              sin_neg;
  } trig_t;

  function automatic logic [MAG_W-1:0] quarter_sine_calc(input int unsigned d);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned t;
    longint unsigned p;
    longint unsigned s;
    x  = (64'(d) * PI_Q30 + 64'd90) / 64'd180;
    x2 = (x * x) >> 30;
    t  = Q30_ONE;
    for (int k = 0; k < 5; k++) begin
      p = (x2 * t) >> 30;
      case (k)
        0:       p = p / 64'd110;
        1:       p = p / 64'd72;
        2:       p = p / 64'd42;
        3:       p = p / 64'd20;
        default: p = p / 64'd6;
      endcase
      t = (p >= Q30_ONE) ? 64'd0 : (Q30_ONE - p);
    end
    s = (x * t) >> 30;
    s = (s + 64'd16384) >> 15;
    if (s > 64'd32767) s = 64'd32767;
    return s[MAG_W-1:0];
  endfunction

  function automatic sine_rom_t build_sine_rom();
    sine_rom_t rom;
    for (int i = 0; i <= int'(QUARTER); i++) begin
      rom[i] = quarter_sine_calc(i);
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

`default_nettype wire

@@ sv/dead_reckoning_odometry.sv @@
// Top level of the dead-reckoning odometry block: stream ports, APB register,
// sequencer. Depends on dro_pkg, dro_smul, dro_trig and dro_acc.
//
// channel  | dir | transfer                   | payload
// s_       | in  | s_tvalid & s_tready        | s_tdata: direction, pulses, heading
// m_       | out | m_tvalid & m_tready        | m_tdata: x, y, cos, sin; m_tuser: bad
// apb      | in  | psel & penable & pwrite    | distance_per_pulse at byte address 0
//
// An item goes from its transfer through the serial distance multiply (one pulse
// bit per cycle), then the two serial projection multiplies (one trig bit per
// cycle), then accumulate and load.
// One item is in work at a time; the next is taken while the result waits.
// Reset clears both positions and restores distance_per_pulse to 16777.
`default_nettype none

module dead_reckoning_odometry
  import dro_pkg::*;
#(
  parameter int unsigned POSITION_FRACTION_BITS = FRAC_DEFAULT
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [23:0]  s_tdata,   // direction_code[1:0], pulse_count[11:2], heading_deg[21:12]
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [127:0]      m_tdata,   // pos_x[47:0], pos_y[95:48], heading_cos[111:96], heading_sin[127:112]
  output logic [0:0]        m_tuser,   // bad_direction[0]
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [2:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIST = 3'd1;
  localparam logic [2:0] ST_MOVE = 3'd2;
  localparam logic [2:0] ST_ACC  = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  logic [2:0]        state;
  logic [2:0]        state_next;
  logic [DPP_W-1:0]  dpp;
  logic [DIR_W-1:0]  dir;
  logic [HEAD_W-1:0] heading;
  logic              accept;
  logic              out_load;
  logic              dist_done;
  logic [DIST_W-1:0] travel;
  logic              move_x_done;
  logic              move_y_done;
  logic [PROD_W-1:0] prod_x;
  logic [PROD_W-1:0] prod_y;
  logic [POS_W-1:0]  pos_x;
  logic [POS_W-1:0]  pos_y;
  trig_t             trig;

  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : {8'd0, dpp};

  always_ff @(posedge clk) begin
    if (rst) begin
      dpp <= DPP_RESET;
    end else if (psel && penable && pwrite && pready && !paddr[2]) begin
      dpp <= pwdata[DPP_W-1:0];
    end
  end

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_load = (state == ST_OUT) && (!m_tvalid || m_tready);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (accept) state_next = ST_DIST;
      ST_DIST: if (dist_done) state_next = ST_MOVE;
      ST_MOVE: if (move_x_done) state_next = ST_ACC;
      ST_ACC:  state_next = ST_OUT;
      ST_OUT:  if (out_load) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      dir     <= s_tdata[1:0];
      heading <= s_tdata[21:12];
    end
    if (out_load) begin
      m_tdata <= {trig.sin_val, trig.cos_val, pos_y, pos_x};
      m_tuser <= dir[1];
    end
  end

  dro_trig u_trig (
    .clk     (clk),
    .heading (heading),
    .trig    (trig)
  );

  dro_smul #(.A_W(DPP_W), .B_W(PULSE_W)) u_dist (
    .clk   (clk),
    .rst   (rst),
    .start (accept),
    .a     (dpp),
    .b     (s_tdata[11:2]),
    .done  (dist_done),
    .prod  (travel)
  );

  dro_smul #(.A_W(DIST_W), .B_W(MAG_W)) u_move_x (
    .clk   (clk),
    .rst   (rst),
    .start (dist_done),
    .a     (travel),
    .b     (trig.sin_mag),
    .done  (move_x_done),
    .prod  (prod_x)
  );

  dro_smul #(.A_W(DIST_W), .B_W(MAG_W)) u_move_y (
    .clk   (clk),
    .rst   (rst),
    .start (dist_done),
    .a     (travel),
    .b     (trig.cos_mag),
    .done  (move_y_done),
    .prod  (prod_y)
  );

  dro_acc #(.FRAC(POSITION_FRACTION_BITS)) u_acc (
    .clk     (clk),
    .rst     (rst),
    .update  ((state == ST_ACC) && !dir[1]),
    .reverse (dir == DIR_REVERSE),
    .prod_x  (prod_x),
    .prod_y  (prod_y),
    .neg_x   (trig.sin_neg),
    .neg_y   (trig.cos_neg),
    .pos_x   (pos_x),
    .pos_y   (pos_y)
  );

  a_dist_done_in_dist: assert property (@(posedge clk) disable iff (rst)
    dist_done |-> state == ST_DIST)
    else $error("distance multiply finished outside its step");

  a_moves_aligned: assert property (@(posedge clk) disable iff (rst)
    (move_x_done || move_y_done) |-> (move_x_done && move_y_done && state == ST_MOVE))
    else $error("projection multiplies out of step");

  a_bad_holds_pos: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ACC && dir[1]) |=> (pos_x == $past(pos_x) && pos_y == $past(pos_y)))
    else $error("position moved on unknown direction");

  a_load_needs_slot: assert property (@(posedge clk) disable iff (rst)
    out_load |-> (!m_tvalid || m_tready))
    else $error("result overwritten before transfer");

endmodule

`default_nettype wire

@@ sv/dro_smul.sv @@
// Bit-serial shift-add multiplier: one multiplier bit per cycle.
// Uses no package; shared by the distance and the projection steps.
`default_nettype none

module dro_smul #(
  parameter int unsigned A_W = 24,
  parameter int unsigned B_W = 10
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic [A_W-1:0]     a,
  input  wire logic [B_W-1:0]     b,
  output logic                    done,
  output logic [A_W+B_W-1:0]      prod
);

  localparam int unsigned CNT_W = $clog2(B_W + 1);

  logic [A_W-1:0]   a_reg;
  logic [CNT_W-1:0] cnt;
  logic             run;
  logic [A_W:0]     sum;

  assign sum = {1'b0, prod[A_W+B_W-1:B_W]} + (prod[0] ? {1'b0, a_reg} : {(A_W+1){1'b0}});

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= CNT_W'(B_W);
      end else if (run) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_reg <= a;
      prod  <= {{A_W{1'b0}}, b};
    end else if (run) begin
      prod <= {sum, prod[B_W-1:1]};
    end
  end

endmodule

`default_nettype wire

@@ sv/dro_trig.sv @@
// Heading reduction and sine/cosine lookup, registered.
// Depends on dro_pkg for the quarter-wave table and the trig_t result.
`default_nettype none

module dro_trig
  import dro_pkg::*;
(
  input  wire logic              clk,
  input  wire logic [HEAD_W-1:0] heading,
  output trig_t                  trig
);

  logic [ANGLE_W-1:0] h_red;
  logic [ANGLE_W-1:0] h_cos;
  logic [ANGLE_W:0]   h_sum;
  logic [MAG_W-1:0]   s_mag;
  logic [MAG_W-1:0]   c_mag;
  logic               s_neg;
  logic               c_neg;

  function automatic logic [IDX_W:0] fold(input logic [ANGLE_W-1:0] a);
    logic [ANGLE_W-1:0] idx;
    logic               neg;
    if (a <= ANGLE_W'(QUARTER)) begin
      idx = a;
      neg = 1'b0;
    end else if (a <= ANGLE_W'(HALF)) begin
      idx = ANGLE_W'(HALF) - a;
      neg = 1'b0;
    end else if (a <= ANGLE_W'(THREE_QUARTER)) begin
      idx = a - ANGLE_W'(HALF);
      neg = 1'b1;
    end else begin
      idx = ANGLE_W'(ANGLE_STEPS) - a;
      neg = 1'b1;
    end
    return {neg, idx[IDX_W-1:0]};
  endfunction

  always_comb begin
    if (heading < HEAD_W'(ANGLE_STEPS)) begin
      h_red = heading[ANGLE_W-1:0];
    end else if (heading < HEAD_W'(2 * ANGLE_STEPS)) begin
      h_red = ANGLE_W'(heading - HEAD_W'(ANGLE_STEPS));
    end else begin
      h_red = ANGLE_W'(heading - HEAD_W'(2 * ANGLE_STEPS));
    end
    h_sum = {1'b0, h_red} + (ANGLE_W+1)'(QUARTER);
    h_cos = (h_sum >= (ANGLE_W+1)'(ANGLE_STEPS)) ?
            ANGLE_W'(h_sum - (ANGLE_W+1)'(ANGLE_STEPS)) : h_sum[ANGLE_W-1:0];
  end

  logic [IDX_W:0] s_fold;
  logic [IDX_W:0] c_fold;

  assign s_fold = fold(h_red);
  assign c_fold = fold(h_cos);
  assign s_mag  = SINE_ROM[s_fold[IDX_W-1:0]];
  assign c_mag  = SINE_ROM[c_fold[IDX_W-1:0]];
  assign s_neg  = s_fold[IDX_W];
  assign c_neg  = c_fold[IDX_W];

  always_ff @(posedge clk) begin
    trig.sin_mag <= s_mag;
    trig.cos_mag <= c_mag;
    trig.sin_neg <= s_neg;
    trig.cos_neg <= c_neg;
    trig.sin_val <= s_neg ? (TRIG_W'(0) - {1'b0, s_mag}) : {1'b0, s_mag};
    trig.cos_val <= c_neg ? (TRIG_W'(0) - {1'b0, c_mag}) : {1'b0, c_mag};
  end

endmodule

`default_nettype wire

@@ sv/dro_acc.sv @@
// Position accumulators: round the projected move, sign it, add with saturation.
// Depends on dro_pkg for widths.
`default_nettype none

module dro_acc
  import dro_pkg::*;
#(
  parameter int unsigned FRAC = FRAC_DEFAULT
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              update,
  input  wire logic              reverse,
  input  wire logic [PROD_W-1:0] prod_x,
  input  wire logic [PROD_W-1:0] prod_y,
  input  wire logic              neg_x,
  input  wire logic              neg_y,
  output logic [POS_W-1:0]       pos_x,
  output logic [POS_W-1:0]       pos_y
);

  localparam int unsigned SHIFT = TRIG_FRAC - FRAC;
  localparam int unsigned SUM_W = PROD_W + 2;

  function automatic logic [POS_W-1:0] step(input logic [POS_W-1:0] acc,
                                            input logic [PROD_W-1:0] prod,
                                            input logic neg);
    logic [PROD_W:0]   rnd;
    logic [SUM_W-1:0]  mag;
    logic [SUM_W-1:0]  delta;
    logic [SUM_W-1:0]  sum;
    logic [SUM_W-POS_W:0] top;
    rnd   = ({1'b0, prod} + ((PROD_W+1)'(1) << (SHIFT - 1))) >> SHIFT;
    mag   = {1'b0, rnd};
    delta = neg ? (SUM_W'(0) - mag) : mag;
    sum   = {{(SUM_W-POS_W){acc[POS_W-1]}}, acc} + delta;
    top   = sum[SUM_W-1:POS_W-1];
    if (top == '0 || top == '1) begin
      return sum[POS_W-1:0];
    end else if (sum[SUM_W-1]) begin
      return {1'b1, {(POS_W-1){1'b0}}};
    end else begin
      return {1'b0, {(POS_W-1){1'b1}}};
    end
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x <= '0;
      pos_y <= '0;
    end else if (update) begin
      pos_x <= step(pos_x, prod_x, reverse ^ neg_x);
      pos_y <= step(pos_y, prod_y, reverse ^ neg_y);
    end
  end

endmodule

`default_nettype wire

@@ tb/dead_reckoning_odometry_test.sv @@
// Regression for dead_reckoning_odometry: directed reports, register extremes,
// random traffic under several idle mixes and a long run at the largest step.
// Depends on dro_pkg and the dead_reckoning_odometry top level only.
`timescale 1ns / 1ps

module dead_reckoning_odometry_test;
  import dro_pkg::*;

  localparam int unsigned FRAC = FRAC_DEFAULT;
  localparam logic [DIR_W-1:0] DIR_FORWARD = 2'd1;
  localparam logic [DIR_W-1:0] DIR_BAD = 2'd2;
  localparam logic [DIR_W-1:0] DIR_BAD_ALT = 2'd3;
  localparam logic [2:0] DPP_ADDR = 3'd0;
  localparam logic [DPP_W-1:0] DPP_MAX = 24'hFFFFFF;
  localparam longint POS_MAX = (64'sd1 <<< (POS_W - 1)) - 64'sd1;
  localparam longint POS_MIN = -(64'sd1 <<< (POS_W - 1));
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES = 64;

  typedef struct packed {
    logic [POS_W-1:0]  pos_x;
    logic [POS_W-1:0]  pos_y;
    logic [TRIG_W-1:0] heading_cos;
    logic [TRIG_W-1:0] heading_sin;
    logic              bad_direction;
  } position_fix_t;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          s_tvalid = 1'b0;
  logic          s_tready;
  logic [23:0]   s_tdata = '0;  // direction_code[1:0], pulse_count[11:2], heading_deg[21:12]
  logic          m_tvalid;
  logic          m_tready = 1'b0;
  logic [127:0]  m_tdata;       // pos_x[47:0], pos_y[95:48], heading_cos[111:96], heading_sin[127:112]
  logic [0:0]    m_tuser;       // bad_direction[0]
  logic          psel = 1'b0;
  logic          penable = 1'b0;
  logic          pwrite = 1'b0;
  logic [2:0]    paddr = '0;
  logic [31:0]   pwdata = '0;
  logic [31:0]   prdata;
  logic          pready;

  longint            odo_x;
  longint            odo_y;
  logic [DPP_W-1:0]  odo_dpp;
  position_fix_t     position_fixes [$];
  int                fail_count = 0;
  int                quiet_cycles = 0;
  int unsigned       sender_gap_pct = 0;
  int unsigned       receiver_stall_pct = 0;

  dead_reckoning_odometry #(
    .POSITION_FRACTION_BITS(FRAC)
  ) dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #4 clk = ~clk;

  function automatic int unsigned quarter_wave_mag(input int unsigned deg);
    longint unsigned taylor_div [5] = '{64'd110, 64'd72, 64'd42, 64'd20, 64'd6};
    longint unsigned angle;
    longint unsigned angle_sq;
    longint unsigned term;
    longint unsigned part;
    longint unsigned mag;
    angle = (64'(deg) * PI_Q30 + 64'd90) / 64'd180;
    angle_sq = (angle * angle) >> 30;
    term = Q30_ONE;
    for (int k = 0; k < 5; k++) begin
      part = ((angle_sq * term) >> 30) / taylor_div[k];
      term = (part >= Q30_ONE) ? 64'd0 : (Q30_ONE - part);
    end
    mag = (angle * term) >> 30;
    mag = (mag + 64'd16384) >> 15;
    if (mag > 64'd32767) mag = 64'd32767;
    return int'(mag);
  endfunction

  function automatic int sine_q15(input int unsigned h);
    if (h <= QUARTER) return int'(quarter_wave_mag(h));
    if (h <= HALF) return int'(quarter_wave_mag(HALF - h));
    if (h <= THREE_QUARTER) return -int'(quarter_wave_mag(h - HALF));
    return -int'(quarter_wave_mag(ANGLE_STEPS - h));
  endfunction

  function automatic longint projected_step(input longint unsigned travel, input logic reverse,
                                            input int trig);
    longint unsigned mag;
    longint unsigned rounded;
    mag = (trig < 0) ? 64'(-trig) : 64'(trig);
    rounded = (travel * mag + (64'd1 << (TRIG_FRAC - FRAC - 1))) >> (TRIG_FRAC - FRAC);
    return (reverse != (trig < 0)) ? -longint'(rounded) : longint'(rounded);
  endfunction

  function automatic longint clamp_position(input longint acc, input longint delta);
    longint sum;
    sum = acc + delta;
    if (sum > POS_MAX) sum = POS_MAX;
    if (sum < POS_MIN) sum = POS_MIN;
    return sum;
  endfunction

  function automatic position_fix_t advance_position(input logic [DIR_W-1:0] dir,
                                                     input logic [PULSE_W-1:0] pulses,
                                                     input logic [HEAD_W-1:0] heading);
    int unsigned     h;
    int              sin_v;
    int              cos_v;
    longint unsigned travel;
    position_fix_t   fix;
    h = int'(heading) % ANGLE_STEPS;
    sin_v = sine_q15(h);
    cos_v = sine_q15((h + QUARTER) % ANGLE_STEPS);
    fix.bad_direction = (dir != DIR_REVERSE) && (dir != DIR_FORWARD);
    if (!fix.bad_direction) begin
      travel = 64'(pulses) * 64'(odo_dpp);
      odo_x = clamp_position(odo_x, projected_step(travel, dir == DIR_REVERSE, sin_v));
      odo_y = clamp_position(odo_y, projected_step(travel, dir == DIR_REVERSE, cos_v));
    end
    fix.pos_x = odo_x[POS_W-1:0];
    fix.pos_y = odo_y[POS_W-1:0];
    fix.heading_cos = 16'(cos_v);
    fix.heading_sin = 16'(sin_v);
    return fix;
  endfunction

  always @(posedge clk) begin
    position_fix_t want;
    position_fix_t got;
    if (rst) begin
      odo_x = 0;
      odo_y = 0;
      odo_dpp = DPP_RESET;
    end else begin
      if (s_tvalid && s_tready)
        position_fixes.push_back(advance_position(s_tdata[1:0], s_tdata[11:2], s_tdata[21:12]));
      if (m_tvalid && m_tready) begin
        got.pos_x = m_tdata[47:0];
        got.pos_y = m_tdata[95:48];
        got.heading_cos = m_tdata[111:96];
        got.heading_sin = m_tdata[127:112];
        got.bad_direction = m_tuser[0];
        if (position_fixes.size() == 0) begin
          $error("unexpected result transfer: pos_x %0d pos_y %0d",
                 $signed(got.pos_x), $signed(got.pos_y));
          fail_count++;
        end else begin
          want = position_fixes.pop_front();
          if (got.pos_x !== want.pos_x) begin
            $error("pos_x expected %0d got %0d", $signed(want.pos_x), $signed(got.pos_x));
            fail_count++;
          end
          if (got.pos_y !== want.pos_y) begin
            $error("pos_y expected %0d got %0d", $signed(want.pos_y), $signed(got.pos_y));
            fail_count++;
          end
          if (got.heading_cos !== want.heading_cos) begin
            $error("heading_cos expected %0d got %0d",
                   $signed(want.heading_cos), $signed(got.heading_cos));
            fail_count++;
          end
          if (got.heading_sin !== want.heading_sin) begin
            $error("heading_sin expected %0d got %0d",
                   $signed(want.heading_sin), $signed(got.heading_sin));
            fail_count++;
          end
          if (got.bad_direction !== want.bad_direction) begin
            $error("bad_direction expected %0d got %0d", want.bad_direction, got.bad_direction);
            fail_count++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("dead_reckoning_odometry regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_report(input logic [DIR_W-1:0] dir, input logic [PULSE_W-1:0] pulses,
                             input logic [HEAD_W-1:0] heading);
    while ($urandom_range(99) < sender_gap_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tdata <= {2'b00, heading, pulses, dir};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (position_fixes.size() != 0) @(posedge clk);
  endtask

  task automatic write_distance_per_pulse(input logic [DPP_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= DPP_ADDR;
    pwdata <= {8'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    odo_dpp = value;
  endtask

  task automatic send_random_report();
    int unsigned            pick;
    logic [DIR_W-1:0]       dir;
    logic [PULSE_W-1:0]     pulses;
    logic [HEAD_W-1:0]      heading;
    pick = $urandom_range(99);
    if (pick < 8) dir = pick[0] ? DIR_BAD : DIR_BAD_ALT;
    else dir = pick[1] ? DIR_FORWARD : DIR_REVERSE;
    case ($urandom_range(9))
      0:       pulses = '0;
      1:       pulses = '1;
      2:       pulses = 10'd999;
      default: pulses = 10'($urandom_range(1023));
    endcase
    if ($urandom_range(3) == 0) heading = 10'(QUARTER * $urandom_range(11) + $urandom_range(1));
    else heading = 10'($urandom_range(1023));
    send_report(dir, pulses, heading);
  endtask

  task automatic test_reset_distance_directed();
    send_report(DIR_FORWARD, 10'd0, 10'd0);
    send_report(DIR_FORWARD, 10'd999, 10'd0);
    send_report(DIR_FORWARD, 10'd999, 10'd90);
    send_report(DIR_FORWARD, 10'd999, 10'd180);
    send_report(DIR_FORWARD, 10'd999, 10'd270);
    send_report(DIR_REVERSE, 10'd999, 10'd359);
    send_report(DIR_REVERSE, 10'd500, 10'd360);
    send_report(DIR_FORWARD, 10'd1023, 10'd719);
    send_report(DIR_FORWARD, 10'd1, 10'd999);
    send_report(DIR_REVERSE, 10'd1023, 10'd45);
    send_report(DIR_BAD, 10'd999, 10'd30);
    send_report(DIR_BAD_ALT, 10'd1023, 10'd1023);
    send_report(DIR_REVERSE, 10'd0, 10'd1000);
    send_report(DIR_FORWARD, 10'd512, 10'd512);
    send_report(DIR_REVERSE, 10'd341, 10'd135);
    drain_results();
  endtask

  task automatic test_distance_register_extremes();
    write_distance_per_pulse(DPP_MAX);
    send_report(DIR_FORWARD, 10'd1023, 10'd60);
    send_report(DIR_REVERSE, 10'd999, 10'd225);
    send_report(DIR_FORWARD, 10'd682, 10'd315);
    drain_results();
    write_distance_per_pulse('0);
    send_report(DIR_FORWARD, 10'd1023, 10'd10);
    send_report(DIR_REVERSE, 10'd999, 10'd200);
    drain_results();
  endtask

  task automatic test_random_reports(input int unsigned gap_pct, input int unsigned stall_pct,
                                     input int count);
    if ($urandom_range(3) == 0) write_distance_per_pulse(24'($urandom_range(DPP_MAX)));
    else write_distance_per_pulse(24'($urandom_range(65535)));
    sender_gap_pct = gap_pct;
    receiver_stall_pct = stall_pct;
    for (int i = 0; i < count; i++) begin
      if (i == count / 2) drain_results();
      send_random_report();
    end
    drain_results();
  endtask

  task automatic test_long_travel();
    sender_gap_pct = 0;
    receiver_stall_pct = 0;
    write_distance_per_pulse(DPP_MAX);
    for (int i = 0; i < 60; i++) send_report(DIR_FORWARD, 10'd1023, 10'd135);
    send_report(DIR_REVERSE, 10'd1023, 10'd135);
    send_report(DIR_REVERSE, 10'd1023, 10'd135);
    send_report(DIR_BAD, 10'd5, 10'd135);
    send_report(DIR_FORWARD, 10'd1023, 10'd135);
    drain_results();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_distance_directed();
    test_distance_register_extremes();
    test_random_reports(0, 0, 280);
    test_random_reports(57, 0, 280);
    test_random_reports(0, 57, 280);
    test_random_reports(14, 14, 280);
    test_long_travel();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && position_fixes.size() == 0) begin
      $display("dead_reckoning_odometry regression: pass");
    end else begin
      $display("dead_reckoning_odometry regression: fail");
    end
    $finish;
  end

endmodule

@@ sim.f @@
sv/dro_pkg.sv
sv/dro_smul.sv
sv/dro_trig.sv
sv/dro_acc.sv
sv/dead_reckoning_odometry.sv
tb/dead_reckoning_odometry_test.sv
